// ----- hdl/wbss_pkg.sv -----
// Package for the wildcard byte signature scan.
// Holds the sizes, the configuration register indexes and the cell control type.
// Used by wbss_cell and wildcard_byte_signature_scan; depends on nothing.
`default_nettype none

package wbss_pkg;

  // Longest signature that the cell row can hold, one cell per byte.
  localparam int unsigned MAX_SIGNATURE_BYTES = 16;
  // Width of the per-region byte counter.
  localparam int unsigned COUNT_BITS = 32;

  // Fixed field widths.
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned SIG_WORD_BITS = 64;
  localparam int unsigned MASK_BITS = 16;
  localparam int unsigned LEN_REG_BITS = 5;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_INDEX_BITS = 3;

  // Width of a used length (1 to MAX_SIGNATURE_BYTES) and of a signature byte index.
  localparam int unsigned LEN_BITS = $clog2(MAX_SIGNATURE_BYTES + 1);
  localparam int unsigned SIG_IDX_BITS =
      (MAX_SIGNATURE_BYTES > 1) ? $clog2(MAX_SIGNATURE_BYTES) : 1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SIG_LOW  = 3'd0,
    CFG_SIG_HIGH = 3'd1,
    CFG_WILDCARD = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_BASE     = 3'd4
  } cfg_index_e;

  // Control handed to each cell of the window row.
  typedef struct packed {
    logic                 shift; // take the neighbor's byte this cycle
    logic                 care;  // position is in use and not a wildcard
    logic [BYTE_BITS-1:0] sig;   // signature byte aligned to this position
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/wbss_cell.sv -----
// One cell of the sliding byte window.
// Holds one window byte, passes it on to the next cell, and compares its incoming byte.
// Depends on wbss_pkg.
`default_nettype none

module wbss_cell (
  input  wire logic                             clk_i,
  input  wire logic [wbss_pkg::BYTE_BITS-1:0]   byte_i,
  input  wire wbss_pkg::cell_ctrl_t             ctrl_i,
  output logic      [wbss_pkg::BYTE_BITS-1:0]   byte_o,
  output logic                                  hit_o
);

  logic [wbss_pkg::BYTE_BITS-1:0] byte_q;

  // The byte arriving from the neighbor is this cell's next content, so it is compared.
  assign hit_o = !ctrl_i.care || (byte_i == ctrl_i.sig);

  // Window byte, shifted along the row on each scanned byte.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- hdl/wildcard_byte_signature_scan.sv -----
// Top level of the wildcard byte signature scan.
// Holds the configuration registers, the row of window cells, the byte counter and the
// result register. Depends on wbss_pkg and wbss_cell.
//
// Usage:
//   Bytes of a memory region enter on the input channel, one per transfer, with
//   region_last_i marking the final byte. The first position where the signature matches
//   (bytes marked in the wildcard mask match anything) gives one result with found_o=1
//   and match_address_o = region base plus match offset. A region that ends without a
//   match gives found_o=0 and address 0. Bytes after a match give nothing until the
//   region ends.
//   The result of a byte is on the output channel in the cycle after its transfer.
//   One byte per cycle is taken while in_ready_o is high; the window compare is done
//   in parallel by the cell row, one cell per signature byte.
//   A single output register holds the result. While it is full and the receiver stalls,
//   in_ready_o is low; it rises again in the cycle the result is taken, so a byte can
//   be accepted in the same cycle as the result transfer.
//   Reset empties the output register, clears the scan state and loads the register
//   defaults (signature length 1, all else zero). The user must write configuration
//   through the plain write port while idle; the block does not enforce this.
`default_nettype none

module wildcard_byte_signature_scan (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port
  input  wire logic                                  cfg_we_i,
  input  wire logic [wbss_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [wbss_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  // Byte input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [wbss_pkg::BYTE_BITS-1:0]        data_byte_i,
  input  wire logic                                  region_last_i,
  // Result output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       found_o,
  output logic      [wbss_pkg::ADDR_BITS-1:0]        match_address_o
);

  localparam int unsigned NCELLS = wbss_pkg::MAX_SIGNATURE_BYTES;

  // Configuration registers
  logic [wbss_pkg::SIG_WORD_BITS-1:0] sig_low_q;
  logic [wbss_pkg::SIG_WORD_BITS-1:0] sig_high_q;
  logic [wbss_pkg::MASK_BITS-1:0]     wildcard_q;
  logic [wbss_pkg::LEN_REG_BITS-1:0]  sig_len_q;
  logic [wbss_pkg::ADDR_BITS-1:0]     base_q;

  // Scan state and result register
  logic [wbss_pkg::COUNT_BITS-1:0]    seen_q, seen_d;
  logic                               done_q, done_d;
  logic                               out_valid_q, out_valid_d;
  logic                               found_q, found_d;
  logic [wbss_pkg::ADDR_BITS-1:0]     addr_q, addr_d;

  logic                               in_xfer;
  logic                               scan;
  logic [wbss_pkg::LEN_BITS-1:0]      len_used;
  logic [2*wbss_pkg::SIG_WORD_BITS-1:0] sig_all;
  logic [wbss_pkg::BYTE_BITS-1:0]     sig_arr [NCELLS];
  logic [wbss_pkg::BYTE_BITS-1:0]     cell_byte [NCELLS];
  logic [NCELLS-1:0]                  cell_hit;
  logic                               window_match;
  logic                               enough;
  logic                               hit;
  logic [wbss_pkg::COUNT_BITS-1:0]    seen_inc;
  logic [wbss_pkg::COUNT_BITS-1:0]    offset;
  logic                               emit;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_low_q  <= '0;
      sig_high_q <= '0;
      wildcard_q <= '0;
      sig_len_q  <= wbss_pkg::LEN_REG_BITS'(1);
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbss_pkg::CFG_SIG_LOW:  sig_low_q  <= cfg_data_i;
        wbss_pkg::CFG_SIG_HIGH: sig_high_q <= cfg_data_i;
        wbss_pkg::CFG_WILDCARD: wildcard_q <= cfg_data_i[wbss_pkg::MASK_BITS-1:0];
        wbss_pkg::CFG_LENGTH:   sig_len_q  <= cfg_data_i[wbss_pkg::LEN_REG_BITS-1:0];
        wbss_pkg::CFG_BASE:     base_q     <= cfg_data_i[wbss_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Length in use: zero counts as one, anything above the row length as the row length.
  always_comb begin
    if (sig_len_q == '0) begin
      len_used = wbss_pkg::LEN_BITS'(1);
    end else if (sig_len_q > wbss_pkg::LEN_REG_BITS'(NCELLS)) begin
      len_used = wbss_pkg::LEN_BITS'(NCELLS);
    end else begin
      len_used = wbss_pkg::LEN_BITS'(sig_len_q);
    end
  end

  assign sig_all = {sig_high_q, sig_low_q};

  // Handshake: the output register frees up when its result is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign scan       = in_xfer && !done_q;

  // Row of window cells. Cell j compares its incoming byte, the byte j places back,
  // against signature byte (length - 1 - j), and then holds it.
  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    logic [wbss_pkg::LEN_BITS-1:0]     idx_full;
    logic [wbss_pkg::SIG_IDX_BITS-1:0] idx;
    logic [wbss_pkg::BYTE_BITS-1:0]    byte_in;
    wbss_pkg::cell_ctrl_t              ctrl;

    assign sig_arr[j] = sig_all[j*wbss_pkg::BYTE_BITS +: wbss_pkg::BYTE_BITS];
    assign idx_full   = len_used - wbss_pkg::LEN_BITS'(1) - wbss_pkg::LEN_BITS'(j);
    assign idx        = idx_full[wbss_pkg::SIG_IDX_BITS-1:0];

    assign ctrl.shift = scan;
    assign ctrl.care  = (wbss_pkg::LEN_BITS'(j) < len_used) && !wildcard_q[idx];
    assign ctrl.sig   = sig_arr[idx];

    if (j == 0) begin : g_head
      assign byte_in = data_byte_i;
    end else begin : g_link
      assign byte_in = cell_byte[j-1];
    end

    wbss_cell u_cell (
      .clk_i  (clk_i),
      .byte_i (byte_in),
      .ctrl_i (ctrl),
      .byte_o (cell_byte[j]),
      .hit_o  (cell_hit[j])
    );
  end

  assign window_match = &cell_hit;

  // Saturating byte count, match decision and match offset.
  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + wbss_pkg::COUNT_BITS'(1);
  assign enough   = seen_inc >= wbss_pkg::COUNT_BITS'(len_used);
  assign hit      = scan && enough && window_match;
  assign offset   = seen_inc - wbss_pkg::COUNT_BITS'(len_used);
  assign emit     = hit || (scan && region_last_i);

  // Next scan state; a region end clears everything for the next region.
  always_comb begin
    seen_d = seen_q;
    done_d = done_q;
    if (scan) begin
      seen_d = seen_inc;
      done_d = hit;
    end
    if (in_xfer && region_last_i) begin
      seen_d = '0;
      done_d = 1'b0;
    end
  end

  // Result register loads on a match or on a region end without one.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    addr_d      = addr_q;
    if (emit) begin
      out_valid_d = 1'b1;
      found_d     = hit;
      addr_d      = hit ? base_q + wbss_pkg::ADDR_BITS'(offset) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    addr_q  <= addr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

  // A no-match result always carries a zero address.
  a_nomatch_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_address_o == '0)
    else $error("no-match result with nonzero address");

  // A region end leaves the scan state cleared.
  a_region_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && region_last_i |=> seen_q == '0 && !done_q)
    else $error("scan state not cleared after region end");

  // Entering the matched state always comes with a found result waiting.
  a_done_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> out_valid_o && found_o)
    else $error("match recorded without a found result");

  // While a match is recorded, no further result is produced.
  a_quiet_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && in_xfer |=> !(out_valid_o && !$past(out_valid_o)))
    else $error("result produced after a match in the same region");

endmodule

`default_nettype wire
